// ----- rtl/core/smr_pkg.sv -----
// ----------------------------------------------------------------------------
// smr_pkg: shared types for the score merge and rank table
// Payload structs of both channels, the controller states, the command
// broadcast to the row of table cells and the fixed field widths.
// ----------------------------------------------------------------------------
package smr_pkg;

	localparam int ID_W     = 32;
	localparam int SCORE_W  = 32;
	localparam int RANK_W   = 5;
	localparam int MAX_EMIT = 32;

	typedef struct packed {
		logic                      clear_first;
		logic [ID_W-1:0]           doc_id;
		logic signed [SCORE_W-1:0] score;
		logic                      last_of_batch;
	} smr_in_t;

	typedef struct packed {
		logic [RANK_W-1:0]         rank;
		logic [ID_W-1:0]           ranked_id;
		logic signed [SCORE_W-1:0] ranked_score;
		logic                      overflowed;
		logic                      last;
	} smr_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_SORT,
		ST_READ
	} smr_state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_MERGE,
		OP_SORT,
		OP_ROTATE
	} smr_op_t;

	typedef struct packed {
		smr_op_t                   op;
		logic                      phase;
		logic                      append;
		logic [ID_W-1:0]           id;
		logic signed [SCORE_W-1:0] score;
	} smr_cmd_t;

endpackage

// ----- rtl/core/smr_if.sv -----
// ----------------------------------------------------------------------------
// smr_if: valid/ready channels of the score merge and rank table
// One interface for the input pairs and one for the ranked results.
// ----------------------------------------------------------------------------
interface smr_in_if import smr_pkg::*; ();
	logic    valid;
	logic    ready;
	smr_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smr_out_if import smr_pkg::*; ();
	logic     valid;
	logic     ready;
	smr_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/smr_cell.sv -----
// ----------------------------------------------------------------------------
// smr_cell: one entry of the ranking table
// Holds an id and a summed score. Merges a broadcast pair, takes part in an
// odd-even transposition sort with its neighbours and rotates for readout.
// ----------------------------------------------------------------------------
module smr_cell import smr_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  logic                      clk,
	input  smr_cmd_t                  cmd,
	input  logic [CW-1:0]             cnt,
	input  logic [ID_W-1:0]           left_id,
	input  logic signed [SCORE_W-1:0] left_score,
	input  logic                      swap_left,
	input  logic [ID_W-1:0]           right_id,
	input  logic signed [SCORE_W-1:0] right_score,
	input  logic [ID_W-1:0]           head_id,
	input  logic signed [SCORE_W-1:0] head_score,
	output logic [ID_W-1:0]           id,
	output logic signed [SCORE_W-1:0] score,
	output logic                      match,
	output logic                      swap_right
);

	localparam logic LANE_ODD = ((IDX % 2) == 1);

	logic [ID_W-1:0]           id_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [ID_W-1:0]           id_d;
	logic signed [SCORE_W-1:0] score_d;
	logic signed [SCORE_W:0]   sum;
	logic signed [SCORE_W-1:0] sat_sum;
	logic                      in_use;

	assign in_use = (CW'(IDX) < cnt);
	assign match  = in_use && (id_q == cmd.id);

	// The pair to the right is swapped only when both entries are in use and
	// strictly out of order, so equal scores never change places.
	assign swap_right = (cmd.op == OP_SORT) && (LANE_ODD == cmd.phase) &&
		(CW'(IDX + 1) < cnt) && (score_q < right_score);

	assign sum = {score_q[SCORE_W-1], score_q} + {cmd.score[SCORE_W-1], cmd.score};

	always_comb begin
		if (sum[SCORE_W] != sum[SCORE_W-1]) begin
			sat_sum = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			sat_sum = sum[SCORE_W-1:0];
		end
	end

	always_comb begin
		id_d    = id_q;
		score_d = score_q;
		case (cmd.op)
			OP_MERGE: begin
				if (match) begin
					score_d = sat_sum;
				end else if (cmd.append && (CW'(IDX) == cnt)) begin
					id_d    = cmd.id;
					score_d = cmd.score;
				end
			end
			OP_SORT: begin
				if (swap_right) begin
					id_d    = right_id;
					score_d = right_score;
				end else if (swap_left) begin
					id_d    = left_id;
					score_d = left_score;
				end
			end
			OP_ROTATE: begin
				// The last entry in use wraps round to the head of the row.
				if (CW'(IDX + 1) == cnt) begin
					id_d    = head_id;
					score_d = head_score;
				end else begin
					id_d    = right_id;
					score_d = right_score;
				end
			end
			default: begin
				id_d    = id_q;
				score_d = score_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		id_q    <= id_d;
		score_q <= score_d;
	end

	assign id    = id_q;
	assign score = score_q;

endmodule

// ----- rtl/core/score_merge_rank_table.sv -----
// Sequence: a pair without last_of_batch is accepted, then merged. A pair with
// last_of_batch is accepted and merged, then the cell row runs its sort phases
// before the first ranked result; results then leave at one result per cycle
// while the sink is ready, as the table rotates once through the entries in use.
// Throughput is set by the sequencer: one pair at a time, no pair during sort
// or readout. Reset empties the table and clears the overflow flag.
// ----------------------------------------------------------------------------
// score_merge_rank_table: accumulate document scores and read them out ranked
// Table of id and saturated Q16.16 score sums held in a row of cells, sorted
// stably by descending score through odd-even transposition, read by rotation.
// ----------------------------------------------------------------------------
module score_merge_rank_table import smr_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	smr_in_if.sink    pair,
	smr_out_if.source ranked
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int PW = $clog2(TABLE_ENTRIES);

	smr_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [PW-1:0] phase_q;
	logic [CW-1:0] k_q;
	logic          out_valid_q;
	smr_out_t      out_q;

	logic                      clr_q;
	logic                      lob_q;
	logic [ID_W-1:0]           id_q;
	logic signed [SCORE_W-1:0] score_q;

	smr_cmd_t      cmd;
	logic [CW-1:0] cnt;
	logic          any_match;
	logic          step;
	logic          emit_now;
	logic          read_done;
	logic          sort_done;
	logic          last_hit;

	logic [ID_W-1:0]           cell_id [TABLE_ENTRIES];
	logic signed [SCORE_W-1:0] cell_score [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0]  match;
	logic [TABLE_ENTRIES-1:0]  swap;

	// During the merge cycle a clear request makes the table look empty.
	assign cnt       = (state_q == ST_MERGE && clr_q) ? '0 : count_q;
	assign any_match = |match;
	assign emit_now  = (k_q < MAX_EMIT);
	assign step      = (state_q == ST_READ) && (!emit_now || !out_valid_q || ranked.ready);
	assign read_done = step && (k_q == count_q - CW'(1));
	assign sort_done = (phase_q == PW'(TABLE_ENTRIES - 1));
	assign last_hit  = (k_q == count_q - CW'(1)) || (k_q == MAX_EMIT - 1);

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		logic [ID_W-1:0]           l_id;
		logic signed [SCORE_W-1:0] l_score;
		logic                      l_swap;
		logic [ID_W-1:0]           r_id;
		logic signed [SCORE_W-1:0] r_score;

		if (i == 0) begin : g_first
			assign l_id    = '0;
			assign l_score = '0;
			assign l_swap  = 1'b0;
		end else begin : g_inner_l
			assign l_id    = cell_id[i-1];
			assign l_score = cell_score[i-1];
			assign l_swap  = swap[i-1];
		end

		if (i == TABLE_ENTRIES - 1) begin : g_last
			assign r_id    = '0;
			assign r_score = '0;
		end else begin : g_inner_r
			assign r_id    = cell_id[i+1];
			assign r_score = cell_score[i+1];
		end

		smr_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.cnt         (cnt),
			.left_id     (l_id),
			.left_score  (l_score),
			.swap_left   (l_swap),
			.right_id    (r_id),
			.right_score (r_score),
			.head_id     (cell_id[0]),
			.head_score  (cell_score[0]),
			.id          (cell_id[i]),
			.score       (cell_score[i]),
			.match       (match[i]),
			.swap_right  (swap[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pair.valid) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				state_d = lob_q ? ST_SORT : ST_IDLE;
			end
			ST_SORT: begin
				if (sort_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (read_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pair.ready = (state_q == ST_IDLE);
		cmd.phase  = phase_q[0];
		cmd.append = !any_match && (cnt < CW'(TABLE_ENTRIES));
		cmd.id     = id_q;
		cmd.score  = score_q;
		case (state_q)
			ST_MERGE: cmd.op = OP_MERGE;
			ST_SORT:  cmd.op = OP_SORT;
			ST_READ:  cmd.op = step ? OP_ROTATE : OP_HOLD;
			default:  cmd.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			phase_q     <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MERGE) begin
				count_q <= cnt + CW'(cmd.append);
				ovf_q   <= (ovf_q && !clr_q) || (!any_match && (cnt == CW'(TABLE_ENTRIES)));
			end
			phase_q <= (state_q == ST_SORT) ? phase_q + PW'(1) : '0;
			if (state_q != ST_READ) begin
				k_q <= '0;
			end else if (step) begin
				k_q <= k_q + CW'(1);
			end
			if (step && emit_now) begin
				out_valid_q <= 1'b1;
			end else if (ranked.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pair.valid && pair.ready) begin
			clr_q   <= pair.data.clear_first;
			id_q    <= pair.data.doc_id;
			score_q <= pair.data.score;
			lob_q   <= pair.data.last_of_batch;
		end
		if (step && emit_now) begin
			out_q.rank         <= RANK_W'(k_q);
			out_q.ranked_id    <= cell_id[0];
			out_q.ranked_score <= cell_score[0];
			out_q.overflowed   <= ovf_q;
			out_q.last         <= last_hit;
		end
	end

	assign ranked.valid = out_valid_q;
	assign ranked.data  = out_q;

endmodule

// ----- rtl/core/smr_checker.sv -----
// ----------------------------------------------------------------------------
// smr_checker: port-level checks for the score merge and rank table
// Watches both channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
module smr_checker import smr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input smr_out_t out_data
);

	// A result that is not taken stays put until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Every accepted pair is followed by its merge cycle, with no transfer.
	a_merge_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pair accepted during the merge cycle");

	// No pair is taken while a readout is still unfinished.
	a_no_pair_mid_readout: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> !in_ready)
		else $error("input ready in the middle of a readout");

endmodule

bind score_merge_rank_table smr_checker u_smr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pair.valid),
	.in_ready  (pair.ready),
	.out_valid (ranked.valid),
	.out_ready (ranked.ready),
	.out_data  (ranked.data)
);
